[rtl/rcc_pkg.sv]
// Shared types and constants for the root counter channel.
`default_nettype none
package rcc_pkg;

  // Channel selection and prescaler divisors.
  localparam int unsigned CHANNEL        = 4;
  localparam int unsigned PIXEL_DIVISOR  = 8;
  localparam int unsigned HBLANK_DIVISOR = 2048;

  // Channels 0 to 2 are 16 bits wide; the rest are 32 bits wide.
  localparam bit NARROW = (CHANNEL < 3);
  localparam logic [31:0] VALUE_MASK = NARROW ? 32'h0000_ffff : 32'hffff_ffff;
  localparam logic [31:0] OVF_LIMIT  = NARROW ? 32'h0000_ffff : 32'hfffe_e000;

  // Channels 0, 1 and 3 use a free divisor on mode bit 8 and gate on bit 0.
  localparam bit ALT_GROUP = (CHANNEL == 0) || (CHANNEL == 1) || (CHANNEL == 3);
  localparam int unsigned ALT_DIV_RAW = (CHANNEL == 0) ? PIXEL_DIVISOR : HBLANK_DIVISOR;
  localparam logic [15:0] ALT_DIV_M1 =
    (ALT_DIV_RAW == 0) ? 16'd0 : 16'(ALT_DIV_RAW - 1);

  // Mode word flags.
  localparam logic [31:0] F_IRQ      = 32'h0000_0400;
  localparam logic [31:0] F_TARGET   = 32'h0000_0800;
  localparam logic [31:0] F_OVERFLOW = 32'h0000_1000;
  localparam logic [31:0] F_STOP     = 32'h0100_0000;

  // Mode word control bits.
  localparam int unsigned B_RESET_ON_TARGET = 3;
  localparam int unsigned B_IRQ_ON_TARGET   = 4;
  localparam int unsigned B_IRQ_ON_OVF      = 5;
  localparam int unsigned B_REPEAT          = 6;
  localparam int unsigned B_TOGGLE          = 7;
  localparam int unsigned B_ALT_SRC         = 8;
  localparam int unsigned B_CH2_DIV8        = 9;

  // Prescale selection codes for channels 4 and 5.
  localparam logic [1:0] PRE_DIV1   = 2'd0;
  localparam logic [1:0] PRE_DIV8   = 2'd1;
  localparam logic [1:0] PRE_DIV16  = 2'd2;
  localparam logic [1:0] PRE_DIV256 = 2'd3;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_COUNT  = 2'd1,
    OP_MODE   = 2'd2,
    OP_TARGET = 2'd3
  } op_t;

  typedef struct packed {
    op_t         operation;
    logic [31:0] write_value;
    logic        irq_pending;
  } in_beat_t;

  typedef struct packed {
    logic [31:0] count_out;
    logic [31:0] mode_out;
    logic        irq_request;
  } out_beat_t;

  typedef struct packed {
    logic [31:0] count;
    logic [31:0] mode;
    logic [31:0] target;
    logic        hold;
    logic [31:0] cycle_number;
    logic [15:0] rem;
  } chan_state_t;

  localparam chan_state_t STATE_RESET = '{
    count:        32'd0,
    mode:         F_IRQ,
    target:       32'd0,
    hold:         1'b0,
    cycle_number: 32'd0,
    rem:          16'd0
  };

endpackage
`default_nettype wire

[rtl/rcc_core.sv]
// Next-state and result logic for one beat of the root counter channel.
`default_nettype none
module rcc_core
  import rcc_pkg::*;
(
  input  wire chan_state_t state_cur,
  input  wire in_beat_t    beat,
  output chan_state_t      state_nxt,
  output out_beat_t        result
);

  logic [31:0] cyc_inc;
  logic [15:0] rem_inc;
  logic        hit;
  logic [31:0] cnt;
  logic [31:0] mode;
  logic        hold;
  logic        irq;
  logic [2:0]  gate;
  logic        gate_on;

  always_comb begin
    state_nxt = state_cur;
    irq       = 1'b0;
    cnt       = state_cur.count;
    mode      = state_cur.mode;
    hold      = state_cur.hold;
    gate      = beat.write_value[2:0];

    // Cycle counter and remainder against the free divisor.
    cyc_inc = state_cur.cycle_number + 32'd1;
    if (cyc_inc == 32'd0 || state_cur.rem == ALT_DIV_M1) begin
      rem_inc = 16'd0;
    end else begin
      rem_inc = state_cur.rem + 16'd1;
    end

    // Prescaler: does the new cycle number land on a multiple of the divisor?
    if (ALT_GROUP) begin
      hit = !state_cur.mode[B_ALT_SRC] || (rem_inc == 16'd0);
    end else if (CHANNEL == 2) begin
      hit = !state_cur.mode[B_CH2_DIV8] || (cyc_inc[2:0] == 3'd0);
    end else begin
      unique case (state_cur.mode[14:13])
        PRE_DIV1:   hit = 1'b1;
        PRE_DIV8:   hit = (cyc_inc[2:0] == 3'd0);
        PRE_DIV16:  hit = (cyc_inc[3:0] == 4'd0);
        PRE_DIV256: hit = (cyc_inc[7:0] == 8'd0);
        default:    hit = 1'b1;
      endcase
    end

    gate_on = ALT_GROUP ? beat.write_value[0] : (gate == 3'd1 || gate == 3'd7);

    unique case (beat.operation)
      OP_TICK: begin
        cnt = state_cur.count + {31'd0, hit};

        // Flags clear once the interrupt controller has taken the request.
        if (!beat.irq_pending) begin
          mode = (mode & ~(F_TARGET | F_OVERFLOW)) | F_IRQ;
        end

        // Target compare.
        if (!hold && cnt >= state_cur.target) begin
          mode = mode | F_TARGET;
          if (mode[B_TOGGLE] && mode[B_IRQ_ON_TARGET]) begin
            mode = mode & ~F_IRQ;
          end
          irq = mode[B_IRQ_ON_TARGET];
          if (mode[B_RESET_ON_TARGET]) begin
            cnt = 32'd0;
          end else begin
            hold = !mode[B_REPEAT];
          end
        end

        // Overflow check.
        if (cnt >= OVF_LIMIT) begin
          mode = mode | F_OVERFLOW;
          if (mode[B_IRQ_ON_OVF]) begin
            irq = 1'b1;
            if (mode[B_TOGGLE]) begin
              mode = mode & ~F_IRQ;
            end
          end
          cnt  = 32'd0;
          hold = 1'b0;
        end

        state_nxt.cycle_number = cyc_inc;
        state_nxt.rem          = rem_inc;
      end
      OP_COUNT: begin
        cnt = beat.write_value & VALUE_MASK;
      end
      OP_MODE: begin
        mode = beat.write_value | F_IRQ;
        if (gate_on) begin
          mode = mode | F_STOP;
        end
        cnt  = 32'd0;
        hold = 1'b0;
      end
      OP_TARGET: begin
        state_nxt.target = beat.write_value & VALUE_MASK;
      end
      default: begin
        cnt = state_cur.count;
      end
    endcase

    state_nxt.count = cnt;
    state_nxt.mode  = mode;
    state_nxt.hold  = hold;

    result.count_out   = cnt;
    result.mode_out    = mode;
    result.irq_request = irq;
  end

endmodule
`default_nettype wire

[rtl/root_counter_channel.sv]
// Top level of one root timer channel with input and result registers.
`default_nettype none
// One root timer channel. Every input beat (a tick or a write of count, mode or
// target) yields exactly one result beat holding the count, the mode word and
// the interrupt request for that step. The block takes one beat per clock
// while the result side does not stall. The accepting edge captures the beat
// in the input register; the result of the next-state logic then loads into
// the result register when that register is free.
// The channel state updates in that same single pass, so consecutive beats see
// each other's effects with no bubbles. A stall on the result side holds the
// result register and lets one further beat wait in the input register.
module root_counter_channel
  import rcc_pkg::*;
(
  input  wire       clk,
  input  wire       rst_n,
  input  wire       in_valid,
  output logic      in_stall,
  input  wire in_beat_t in_data,
  output logic      out_valid,
  input  wire       out_stall,
  output out_beat_t out_data
);

  logic        in_valid_r;
  in_beat_t    in_data_r;
  logic        out_valid_r;
  out_beat_t   out_data_r;
  chan_state_t state_r;
  chan_state_t state_nxt;
  out_beat_t   result;
  logic        advance;
  logic        step;

  // The result register frees up when empty or when its beat is taken.
  assign advance  = !out_valid_r || !out_stall;
  assign step     = in_valid_r && advance;
  assign in_stall = in_valid_r && !advance;

  rcc_core u_core (
    .state_cur (state_r),
    .beat      (in_data_r),
    .state_nxt (state_nxt),
    .result    (result)
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
    if (!in_stall && in_valid) begin
      in_data_r <= in_data;
    end
  end

  // Channel state and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= STATE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (step) begin
        state_r <= state_nxt;
      end
      if (advance) begin
        out_valid_r <= in_valid_r;
      end
    end
    if (step) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  // Writes never raise the interrupt.
  a_no_irq_on_write: assert property (@(posedge clk) disable iff (!rst_n)
    (step && in_data_r.operation != OP_TICK) |=> !out_data_r.irq_request)
    else $error("interrupt raised by a write beat");

  // A mode write restarts the count and leaves the interrupt flag set.
  a_mode_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (step && in_data_r.operation == OP_MODE) |=>
      (state_r.count == 32'd0 && ((state_r.mode & F_IRQ) != 32'd0) && !state_r.hold))
    else $error("mode write did not restart the channel");

  // Each tick advances the cycle number by exactly one.
  a_cycle_step: assert property (@(posedge clk) disable iff (!rst_n)
    (step && in_data_r.operation == OP_TICK) |=>
      (state_r.cycle_number == 32'($past(state_r.cycle_number) + 32'd1)))
    else $error("cycle number did not advance by one");

  // The input side stalls only while a beat waits in the input register.
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (in_valid_r && out_valid_r))
    else $error("input stalled with room available");
`endif

endmodule
`default_nettype wire
